FILE: src/kgr_pkg.sv
// Shared types and constants for the k-group reverser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package kgr_pkg;

    // Widths of the fields on the ports
    localparam int FIELD_W = 32;
    localparam int GS_W    = 5;

    // Defaults for the top-level parameters
    localparam int GROUP_MAX_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // Group size after reset
    localparam logic [GS_W-1:0] GS_RESET = 5'd2;

    // Element count width: covers a group of up to 127 entries
    localparam int CNT_W = 7;

    // Descriptor queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = 1;

    // One closed group waiting to be emitted
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             last;
    } grp_desc_t;

    // Back part hands a drained bank back to the front part
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

FILE: src/kgr_buf.sv
// Two-bank element buffer: one write port, one registered read port.
// Depends on kgr_pkg for its parameter defaults.
`timescale 1ns / 1ps

module kgr_buf import kgr_pkg::*; #(
    parameter int DEPTH = 2 * GROUP_MAX_DEF,
    parameter int WIDTH = VALUE_WIDTH_DEF,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/kgr_queue.sv
// Short descriptor queue between the front and back parts.
// Depends on kgr_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module kgr_queue import kgr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  grp_desc_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output grp_desc_t head
);

    grp_desc_t            entry [Q_DEPTH];
    logic [Q_PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [Q_PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [Q_PW:0]        count_reg, count_next;
    logic                 do_push, do_pop;

    assign full       = (count_reg == (Q_PW + 1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/kgr_front.sv
// Front part: holds the group size, takes elements into the current bank
// and closes a group into a descriptor. Depends on kgr_pkg.
`timescale 1ns / 1ps

module kgr_front import kgr_pkg::*; #(
    parameter int GROUP_MAX   = GROUP_MAX_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [GS_W-1:0]        cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FIELD_W-1:0]     in_value,
    input  logic                   in_last,
    output logic                   buf_wr_en,
    output logic [AW-1:0]          buf_wr_addr,
    output logic [VALUE_WIDTH-1:0] buf_wr_data,
    output logic                   q_push,
    output grp_desc_t              q_data,
    input  logic                   q_full,
    input  bank_rel_t              rel
);

    localparam int IW = AW - 1;

    logic [GS_W-1:0]  gs_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic [CNT_W-1:0] eff_size;
    logic [CNT_W-1:0] n_fill;
    logic             accept, grp_full, close;

    // Zero acts as one, anything above capacity as capacity
    always_comb begin
        eff_size = (gs_reg == '0) ? CNT_W'(1) : CNT_W'(gs_reg);
        if (eff_size > CNT_W'(GROUP_MAX)) begin
            eff_size = CNT_W'(GROUP_MAX);
        end
    end

    assign in_ready = !busy_reg[bank_reg] && !q_full;
    assign accept   = in_valid && in_ready;
    assign n_fill   = fill_reg + 1'b1;
    assign grp_full = (n_fill >= eff_size);
    assign close    = accept && (grp_full || in_last);

    assign buf_wr_en   = accept;
    assign buf_wr_addr = {bank_reg, IW'(fill_reg)};
    assign buf_wr_data = VALUE_WIDTH'(in_value);

    assign q_push = close;
    always_comb begin
        q_data.bank  = bank_reg;
        q_data.count = n_fill;
        q_data.rev   = grp_full;
        q_data.last  = in_last;
    end

    always_comb begin
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        if (rel.valid) begin
            busy_next[rel.bank] = 1'b0;
        end
        if (close) begin
            // hand the bank to the back part and switch over
            fill_next           = '0;
            bank_next           = !bank_reg;
            busy_next[bank_reg] = 1'b1;
        end else if (accept) begin
            fill_next = n_fill;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gs_reg   <= GS_RESET;
            fill_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                gs_reg <= cfg_wr_data;
            end
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: src/kgr_back.sv
// Back part: walks each closed group through the buffer, newest first for a
// full group, and drives the result stream. Depends on kgr_pkg.
`timescale 1ns / 1ps

module kgr_back import kgr_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int AW          = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  grp_desc_t              q_head,
    output logic                   q_pop,
    output logic                   buf_rd_en,
    output logic [AW-1:0]          buf_rd_addr,
    input  logic [VALUE_WIDTH-1:0] buf_rd_data,
    output bank_rel_t              rel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [FIELD_W-1:0]     m_value,
    output logic                   m_last
);

    localparam int IW = AW - 1;

    grp_desc_t        desc_reg, desc_next;
    logic             active_reg, active_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             a_valid_reg, a_last_reg;
    logic             m_valid_reg, m_last_reg;
    logic [FIELD_W-1:0] m_value_reg;

    grp_desc_t        grp;
    logic             have, issue, issue_ok, a_adv, is_end;
    logic [CNT_W-1:0] idx, pos;

    assign grp  = active_reg ? desc_reg : q_head;
    assign have = active_reg || q_valid;
    assign idx  = active_reg ? idx_reg : '0;

    assign a_adv    = a_valid_reg && (!m_valid_reg || m_ready);
    assign issue_ok = !a_valid_reg || a_adv;
    assign issue    = have && issue_ok;
    assign is_end   = (idx == grp.count - 1'b1);
    assign pos      = grp.rev ? (grp.count - 1'b1 - idx) : idx;

    assign q_pop       = issue && !active_reg;
    assign buf_rd_en   = issue;
    assign buf_rd_addr = {grp.bank, IW'(pos)};

    // Bank goes back once its final read is issued
    assign rel.valid = issue && is_end;
    assign rel.bank  = grp.bank;

    always_comb begin
        desc_next   = desc_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        if (issue) begin
            desc_next   = grp;
            active_next = !is_end;
            idx_next    = idx + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            if (issue) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        idx_reg  <= idx_next;
        if (issue) begin
            a_last_reg <= grp.last && is_end;
        end
        if (a_adv) begin
            m_value_reg <= FIELD_W'(buf_rd_data);
            m_last_reg  <= a_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;
    assign m_last  = m_last_reg;

endmodule

FILE: src/k_group_reverser.sv
// K-group reverser: stream in, stream out, group size register.
// Usage:
//   s_axis_*  list elements, tlast on the final element of a list.
//   m_axis_*  reordered elements; each complete group of group_size comes out
//             newest first, a partial group left by tlast in arrival order,
//             and tlast marks the final output element of the list.
//   cfg_wr_*  writes group_size (0 acts as 1, above GROUP_MAX as GROUP_MAX);
//             write it only while no list is in flight.
// Path: a closed group goes through the descriptor queue, the buffer read
//   register and the output register before its first element is on m_axis.
// Throughput: one element per cycle sustained while m_axis_tready is high.
//   Elements are written into one of two buffer banks while the other bank is
//   read out, one read per cycle from the single read port; s_axis_tready
//   drops only while both banks still hold groups that are waiting to leave.
// Reset: aresetn low clears the fill count, bank state, queue and output
//   register and sets group_size to 2. Buffer contents are not cleared.
// Stall: with m_axis_tready low the output and read stages hold; once both
//   banks are full the input side stalls as well.
// Depends on kgr_pkg, kgr_front, kgr_queue, kgr_back and kgr_buf.
`timescale 1ns / 1ps

module k_group_reverser import kgr_pkg::*; #(
    parameter int GROUP_MAX   = GROUP_MAX_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [GS_W-1:0]    cfg_wr_data,   // group_size
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [FIELD_W-1:0] s_axis_tdata,  // [31:0] elem_value
    input  logic               s_axis_tlast,  // elem_last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [FIELD_W-1:0] m_axis_tdata,  // [31:0] out_value
    output logic               m_axis_tlast   // out_last
);

    localparam int IW    = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 * (1 << IW);

    logic                   buf_wr_en, buf_rd_en;
    logic [AW-1:0]          buf_wr_addr, buf_rd_addr;
    logic [VALUE_WIDTH-1:0] buf_wr_data, buf_rd_data;
    logic                   q_push, q_full, q_pop, q_valid;
    grp_desc_t              q_data, q_head;
    bank_rel_t              rel;

    kgr_front #(
        .GROUP_MAX   (GROUP_MAX),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_value    (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .buf_wr_en   (buf_wr_en),
        .buf_wr_addr (buf_wr_addr),
        .buf_wr_data (buf_wr_data),
        .q_push      (q_push),
        .q_data      (q_data),
        .q_full      (q_full),
        .rel         (rel)
    );

    kgr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    kgr_buf #(
        .DEPTH (DEPTH),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (buf_wr_data),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    kgr_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .buf_rd_en   (buf_rd_en),
        .buf_rd_addr (buf_rd_addr),
        .buf_rd_data (buf_rd_data),
        .rel         (rel),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_value     (m_axis_tdata),
        .m_last      (m_axis_tlast)
    );

endmodule

FILE: src/kgr_checker.sv
// Port-level checks for the k-group reverser, bound to the top level.
// Depends on kgr_pkg for field widths.
`timescale 1ns / 1ps

module kgr_checker import kgr_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [FIELD_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    // Requests taken in but not yet delivered
    logic [15:0] pend_reg;
    logic        s_acc, m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 16'(s_acc) - 16'(m_acc);
        end
    end

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> pend_reg != '0)
        else $error("result offered with no request outstanding");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind k_group_reverser kgr_checker u_kgr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb.sv
// Self-checking bench for k_group_reverser: directed lists, back-pressure and random lists.
// It predicts the reordered stream on its own and compares every output request.
// Depends on kgr_pkg and k_group_reverser.
`timescale 1ns / 1ps

module tb;
    import kgr_pkg::*;

    typedef struct {
        logic [FIELD_W-1:0] value;
        logic               last;
    } out_elem_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [GS_W-1:0]    cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [FIELD_W-1:0] s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [FIELD_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    // Predictor state
    logic [FIELD_W-1:0] grp_buf [GROUP_MAX_DEF];
    int                 grp_fill;
    logic [GS_W-1:0]    grp_size;
    out_elem_t          reordered_q [$];

    // Sender and receiver pacing
    int gap_max;
    int burst_max;
    int burst_left;
    int stall_pct;
    int hold_left;
    int err_count;

    k_group_reverser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int eff_group(input logic [GS_W-1:0] gs);
        if (gs == 0) begin
            return 1;
        end
        if (gs > GROUP_MAX_DEF) begin
            return GROUP_MAX_DEF;
        end
        return int'(gs);
    endfunction

    // Buffer one element; on a full group or list end, queue the reordered outputs.
    function automatic void reorder_element(input logic [FIELD_W-1:0] v, input logic l);
        int        eff;
        int        n;
        bit        full;
        out_elem_t r;
        eff = eff_group(grp_size);
        grp_buf[grp_fill] = v;
        grp_fill++;
        n = grp_fill;
        full = (n >= eff);
        if (full || l) begin
            for (int i = 0; i < n; i++) begin
                r.value = grp_buf[full ? n - 1 - i : i];
                r.last  = l && (i == n - 1);
                reordered_q.push_back(r);
            end
            grp_fill = 0;
        end
    endfunction

    function automatic logic [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_elem(input logic [FIELD_W-1:0] v, input logic l);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= l;
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        reorder_element(v, l);
    endtask

    // Hold the input until every predicted output has arrived, then let the pipe settle.
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (reordered_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_group_size(input logic [GS_W-1:0] gs);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= gs;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        grp_size = gs;
    endtask

    task automatic send_list(input int len);
        for (int i = 0; i < len; i++) begin
            send_elem(rand_value(), i == len - 1);
        end
    endtask

    task automatic test_reset_size();
        gap_max   = 0;
        burst_max = 8;
        stall_pct = 0;
        // Two reversed pairs, then a single leftover with the end flag.
        send_elem(32'h8000_0000, 1'b0);
        send_elem(32'h7FFF_FFFF, 1'b0);
        send_elem(32'hFFFF_FFFF, 1'b0);
        send_elem(32'h0000_0000, 1'b0);
        send_elem(32'h5A5A_A5A5, 1'b1);
        drain_outputs();
    endtask

    task automatic test_size_limits();
        gap_max   = 3;
        burst_max = 2;
        stall_pct = 30;
        // Zero acts as one: pass-through.
        set_group_size(5'd0);
        send_elem(32'hA5A5_5A5A, 1'b0);
        send_elem(32'h0000_0001, 1'b1);
        drain_outputs();
        // Oversize clamps to GROUP_MAX; a short list comes out in order.
        set_group_size(5'd31);
        send_elem(32'h1234_5678, 1'b0);
        send_elem(32'hFEDC_BA98, 1'b0);
        send_elem(32'h8000_0001, 1'b1);
        drain_outputs();
        set_group_size(5'd1);
        send_elem(32'hFFFF_FFFE, 1'b1);
        drain_outputs();
        // Group closes on the end-flagged element: reversed, flag on the oldest.
        set_group_size(5'd3);
        send_elem(32'h0000_0003, 1'b0);
        send_elem(32'h0000_0002, 1'b0);
        send_elem(32'h0000_0001, 1'b1);
        drain_outputs();
    endtask

    task automatic test_size_shrink();
        gap_max   = 0;
        stall_pct = 0;
        set_group_size(5'd8);
        send_elem(32'h0000_0011, 1'b0);
        send_elem(32'h0000_0022, 1'b0);
        send_elem(32'h0000_0033, 1'b0);
        drain_outputs();
        // Buffer already past the new size: flush all four reversed.
        set_group_size(5'd2);
        send_elem(32'h0000_0044, 1'b0);
        send_elem(32'h0000_0055, 1'b1);
        drain_outputs();
    endtask

    task automatic test_backpressure();
        gap_max   = 0;
        burst_max = 64;
        stall_pct = 0;
        set_group_size(5'd4);
        // Keep the output blocked so both banks fill and the input stalls.
        hold_left = 80;
        for (int i = 0; i < 22; i++) begin
            send_elem(rand_value(), 1'b0);
        end
        // Pause mid-list until everything predicted has come out.
        drain_outputs();
        send_elem(rand_value(), 1'b0);
        send_elem(rand_value(), 1'b0);
        send_elem(rand_value(), 1'b1);
        drain_outputs();
    endtask

    task automatic test_random_lists();
        int              n_items;
        int              phase;
        int              len;
        logic [GS_W-1:0] gs;
        logic [GS_W-1:0] first_sizes [5];
        first_sizes = '{5'd16, 5'd1, 5'd31, 5'd17, 5'd0};
        n_items = 0;
        phase   = 0;
        while (n_items < 136 || phase < 5) begin
            gs = (phase < 5) ? first_sizes[phase] : GS_W'($urandom_range(0, 31));
            set_group_size(gs);
            gap_max   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
            burst_max = $urandom_range(1, 12);
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 20;
                default: stall_pct = 60;
            endcase
            repeat ($urandom_range(1, 3)) begin
                len = $urandom_range(1, 2 * eff_group(gs) + 2);
                send_list(len);
                n_items += len;
            end
            drain_outputs();
            phase++;
        end
    endtask

    // Output side: check each accepted request, then choose next tready.
    initial begin
        int        run_left;
        out_elem_t want;
        run_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (reordered_q.size() == 0) begin
                    $error("unexpected output: out_value %h out_last %b",
                           m_axis_tdata, m_axis_tlast);
                    err_count++;
                end else begin
                    want = reordered_q.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("out_value: expected %h, got %h", want.value, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("out_last: expected %b, got %b", want.last, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                run_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        err_count  = 0;
        hold_left  = 0;
        stall_pct  = 0;
        gap_max    = 0;
        burst_max  = 8;
        burst_left = 0;
        grp_fill   = 0;
        grp_size   = GS_RESET;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_size();
        test_size_limits();
        test_size_shrink();
        test_backpressure();
        test_random_lists();

        drain_outputs();
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/kgr_pkg.sv
src/kgr_buf.sv
src/kgr_queue.sv
src/kgr_front.sv
src/kgr_back.sv
src/k_group_reverser.sv
src/kgr_checker.sv
bench/tb.sv
